// ----- src/sorted_table_binary_search_top_defines.svh -----
// assertion macros for the sorted table binary search block
// no dependencies; taken in by the files that carry assertions
`ifndef SORTED_TABLE_BINARY_SEARCH_TOP_DEFINES_SVH
`define SORTED_TABLE_BINARY_SEARCH_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define STBS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define STBS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/stbs_pkg.sv -----
// shared types and constants for the sorted table binary search block
// used by the interfaces, the controller, the datapath and the top level
package stbs_pkg;

  localparam int KEY_W       = 32;
  localparam int INDEX_W     = 10;
  localparam int LENGTH_W    = 11;
  localparam int POS_W       = 10;
  localparam int COUNT_W     = 6;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 11;

  localparam int TABLE_DEPTH_DEFAULT = 1024;

  localparam logic [COUNT_W:0] COUNT_MAX = 7'd63;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam logic MODE_THREE_WAY   = 1'b0;
  localparam logic MODE_LOWER_BOUND = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] CFG_SEARCH_MODE  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TABLE_LENGTH = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_CHECK,
    S_FINAL_CHECK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic write;
    logic load;
    logic rd_en;
    logic step;
    logic final_chk;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic mode;
    logic empty;
    logic lo_lt_bound;
    logic eq;
    logic out_busy;
  } dp_status_t;

endpackage

// ----- src/stbs_interfaces.sv -----
// valid/ready channel interfaces: request items, result items, register writes
// depends on stbs_pkg for field widths
interface stbs_req_if;
  logic                                valid;
  logic                                ready;
  logic                                opcode;
  logic [stbs_pkg::INDEX_W-1:0]        write_index;
  logic signed [stbs_pkg::KEY_W-1:0]   write_value;
  logic signed [stbs_pkg::KEY_W-1:0]   search_key;

  modport source (output valid, opcode, write_index, write_value, search_key, input ready);
  modport sink (input valid, opcode, write_index, write_value, search_key, output ready);
endinterface

interface stbs_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [stbs_pkg::POS_W-1:0]    match_position;
  logic [stbs_pkg::COUNT_W-1:0]  comparison_count;

  modport source (output valid, found, match_position, comparison_count, input ready);
  modport sink (input valid, found, match_position, comparison_count, output ready);
endinterface

interface stbs_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [stbs_pkg::CFG_INDEX_W-1:0]  index;
  logic [stbs_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- src/stbs_datapath.sv -----
// datapath: key table memory, config registers, search bounds, compare and result register
// depends on stbs_pkg and stbs_interfaces
module stbs_datapath #(
  parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  stbs_cfg_if.sink                          cfg,
  stbs_rsp_if.source                        rsp,
  input  logic [stbs_pkg::INDEX_W-1:0]      write_index,
  input  logic signed [stbs_pkg::KEY_W-1:0] write_value,
  input  logic signed [stbs_pkg::KEY_W-1:0] search_key,
  input  stbs_pkg::dp_cmd_t                 cmd,
  output stbs_pkg::dp_status_t              status
);
  import stbs_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int LEN_W = ($clog2(TABLE_DEPTH + 1) > LENGTH_W) ?
                         $clog2(TABLE_DEPTH + 1) : LENGTH_W;
  localparam logic [LEN_W-1:0] DEPTH_L = LEN_W'(TABLE_DEPTH);

  logic signed [KEY_W-1:0] key_table [TABLE_DEPTH];

  logic                    search_mode;
  logic [LENGTH_W-1:0]     table_length;
  logic signed [KEY_W-1:0] key;
  logic signed [KEY_W-1:0] rd_data;
  logic [LEN_W-1:0]        lo;
  logic [LEN_W-1:0]        bound;
  logic [LEN_W-1:0]        span;
  logic [LEN_W-1:0]        mid;
  logic [LEN_W-1:0]        len_ext;
  logic [LEN_W-1:0]        len_eff;
  logic [LEN_W-1:0]        widx_ext;
  logic [LEN_W-1:0]        pos;
  logic                    empty;
  logic                    hit;
  logic [COUNT_W-1:0]      cnt;
  logic [COUNT_W-1:0]      cnt_next;
  logic [COUNT_W:0]        cnt_sum;
  logic [1:0]              cnt_inc;
  logic                    eq;
  logic                    lt;
  logic [IDX_W-1:0]        rd_addr;

  // register writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      search_mode  <= MODE_THREE_WAY;
      table_length <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_SEARCH_MODE:  search_mode  <= cfg.data[0];
        CFG_TABLE_LENGTH: table_length <= cfg.data;
        default: ;
      endcase
    end
  end

  assign len_ext  = LEN_W'(table_length);
  assign len_eff  = (len_ext > DEPTH_L) ? DEPTH_L : len_ext;
  assign widx_ext = LEN_W'(write_index);

  // three-way keeps an exclusive upper bound, lower-bound an inclusive one
  assign span    = bound - lo - ((search_mode == MODE_THREE_WAY) ? LEN_W'(1) : LEN_W'(0));
  assign mid     = lo + (span >> 1);
  assign rd_addr = (lo < bound) ? mid[IDX_W-1:0] : lo[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.write && (widx_ext < DEPTH_L)) begin
      key_table[widx_ext[IDX_W-1:0]] <= write_value;
    end
    if (cmd.rd_en) begin
      rd_data <= key_table[rd_addr];
    end
  end

  assign eq = (rd_data == key);
  assign lt = (rd_data < key);

  assign cnt_inc  = (cmd.step && (search_mode == MODE_THREE_WAY) && !eq) ? 2'd2 : 2'd1;
  assign cnt_sum  = {1'b0, cnt} + (COUNT_W + 1)'(cnt_inc);
  assign cnt_next = (cnt_sum > COUNT_MAX) ? COUNT_MAX[COUNT_W-1:0] : cnt_sum[COUNT_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key   <= search_key;
      lo    <= '0;
      bound <= (search_mode == MODE_THREE_WAY) ? len_eff : len_eff - LEN_W'(1);
      empty <= (len_eff == '0);
      cnt   <= '0;
      hit   <= 1'b0;
      pos   <= '0;
    end else if (cmd.step) begin
      cnt <= cnt_next;
      if ((search_mode == MODE_THREE_WAY) && eq) begin
        hit <= 1'b1;
        pos <= mid;
      end else if (lt) begin
        lo <= mid + LEN_W'(1);
      end else begin
        bound <= mid;
      end
    end else if (cmd.final_chk) begin
      cnt <= cnt_next;
      hit <= eq;
      pos <= eq ? lo : '0;
    end
  end

  // result register, frees up as soon as the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp.found            <= hit;
      rsp.match_position   <= pos[POS_W-1:0];
      rsp.comparison_count <= cnt;
    end
  end

  assign status.mode        = search_mode;
  assign status.empty       = empty;
  assign status.lo_lt_bound = (lo < bound);
  assign status.eq          = eq;
  assign status.out_busy    = rsp.valid && !rsp.ready;

endmodule

// ----- src/stbs_ctrl.sv -----
// controller state machine: accepts items, sequences table probes, hands off results
// depends on stbs_pkg, stbs_interfaces and the assertion macro header
`include "sorted_table_binary_search_top_defines.svh"

module stbs_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  stbs_req_if.sink                   req,
  input  stbs_pkg::dp_status_t       status,
  output stbs_pkg::dp_cmd_t          cmd
);
  import stbs_pkg::*;

  state_t state;
  state_t state_next;
  logic   accept;
  logic   search_accept;
  logic   comparing;

  assign accept        = req.valid && req.ready;
  assign search_accept = accept && (req.opcode == OP_SEARCH);
  assign comparing     = (state == S_CHECK) || (state == S_FINAL_CHECK);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && (req.opcode == OP_SEARCH)) begin
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        if (status.empty) begin
          state_next = S_DONE;
        end else if (status.lo_lt_bound) begin
          state_next = S_CHECK;
        end else if (status.mode == MODE_THREE_WAY) begin
          state_next = S_DONE;
        end else begin
          state_next = S_FINAL_CHECK;
        end
      end
      S_CHECK: begin
        if ((status.mode == MODE_THREE_WAY) && status.eq) begin
          state_next = S_DONE;
        end else begin
          state_next = S_PROBE;
        end
      end
      S_FINAL_CHECK: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!status.out_busy) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    req.ready = 1'b0;
    cmd       = '0;
    case (state)
      S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          cmd.write = (req.opcode == OP_WRITE);
          cmd.load  = (req.opcode == OP_SEARCH);
        end
      end
      S_PROBE: begin
        // read mid while the range is open, else the surviving entry for lower-bound
        cmd.rd_en = !status.empty &&
                    (status.lo_lt_bound || (status.mode == MODE_LOWER_BOUND));
      end
      S_CHECK: begin
        cmd.step = 1'b1;
      end
      S_FINAL_CHECK: begin
        cmd.final_chk = 1'b1;
      end
      S_DONE: begin
        cmd.out_load = !status.out_busy;
      end
      default: ;
    endcase
  end

  `STBS_ASSERT_SAME(a_out_load_free, clk, rst, cmd.out_load, !status.out_busy, "load while busy")
  `STBS_ASSERT_NEXT(a_read_then_compare, clk, rst, cmd.rd_en, comparing, "read without compare")
  `STBS_ASSERT_NEXT(a_search_starts, clk, rst, search_accept, state == S_PROBE, "no probe")

endmodule

// ----- src/sorted_table_binary_search_top.sv -----
// Sorted table binary search. Write items store one signed key each and give no
// result; search items return found, match position and comparison count over the
// first table_length entries. A search makes at most log2(TABLE_DEPTH) + 1 table reads,
// 11 for the default depth: each read is a registered read of the key table
// followed by a compare, and a lower-bound search spends its last read on the final
// equality check. A three-way search that misses goes back to the probe state once more
// to see the range close, and an empty table goes from the probe state straight to the
// result. A result waits while the output register still holds an untaken one; the next
// item is accepted once the result sits in the output register.
// top level: joins the controller and datapath to the request, result and config channels
// depends on stbs_pkg, stbs_interfaces, stbs_ctrl and stbs_datapath
module sorted_table_binary_search_top #(
  parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  stbs_req_if.sink    req,
  stbs_rsp_if.source  rsp,
  stbs_cfg_if.sink    cfg
);
  import stbs_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  stbs_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .status (status),
    .cmd    (cmd)
  );

  stbs_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .rsp         (rsp),
    .write_index (req.write_index),
    .write_value (req.write_value),
    .search_key  (req.search_key),
    .cmd         (cmd),
    .status      (status)
  );

endmodule

// ----- tb/tb_top.sv -----
// self-checking testbench for sorted_table_binary_search_top: a directed table, then
// a full sorted fill and randomized phases of searches and writes under idling and stalling
// depends on stbs_pkg, stbs_interfaces and the rtl top level
module tb_top;
  import stbs_pkg::*;

  localparam int TABLE_DEPTH    = TABLE_DEPTH_DEFAULT;
  localparam int CLK_PERIOD     = 20;
  localparam int TIMEOUT_CYCLES = 1000000;
  // writes give no result, so wait past the longest search
  localparam int DRAIN_CYCLES   = 32;
  localparam int PHASE_ITEMS    = 8;
  localparam int NUM_PHASES     = 16;
  localparam int KEY_MIN        = 32'sh8000_0000;
  localparam int KEY_MAX        = 32'sh7fff_ffff;

  typedef struct packed {
    logic               found;
    logic [POS_W-1:0]   pos;
    logic [COUNT_W-1:0] cnt;
  } search_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t               kind;
    logic                    op;
    logic [INDEX_W-1:0]      idx;
    int                      val;
    int                      key;
    logic [CFG_INDEX_W-1:0]  sel;
    logic [CFG_DATA_W-1:0]   cdata;
    bit                      typed;
    search_result_t          want;
  } stim_row_t;

  logic clk;
  logic rst;

  stbs_req_if req_ch();
  stbs_rsp_if rsp_ch();
  stbs_cfg_if cfg_ch();

  sorted_table_binary_search_top #(.TABLE_DEPTH(TABLE_DEPTH)) uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  int                   key_mirror [TABLE_DEPTH];
  logic                 cur_mode;
  logic [LENGTH_W-1:0]  cur_length;
  search_result_t       pending_results [$];
  stim_row_t            dir_rows [$];
  int                   send_idle_pct;
  int                   recv_stall_pct;
  int                   errors = 0;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("TB_ERROR");
    $finish;
  end

  function automatic search_result_t predict_search(int key);
    search_result_t r;
    int n, lo, hi, mid, cmp;
    r = '0;
    cmp = 0;
    n = (cur_length > TABLE_DEPTH) ? TABLE_DEPTH : int'(cur_length);
    if (n > 0) begin
      lo = 0;
      hi = n - 1;
      if (cur_mode == MODE_THREE_WAY) begin
        while (lo <= hi && !r.found) begin
          mid = lo + (hi - lo) / 2;
          cmp++;
          if (key_mirror[mid] == key) begin
            r.found = 1'b1;
            r.pos = POS_W'(mid);
          end else begin
            cmp++;
            if (key_mirror[mid] < key) lo = mid + 1;
            else hi = mid - 1;
          end
        end
      end else begin
        while (lo < hi) begin
          mid = lo + (hi - lo) / 2;
          cmp++;
          if (key_mirror[mid] < key) lo = mid + 1;
          else hi = mid;
        end
        cmp++;
        if (key_mirror[lo] == key) begin
          r.found = 1'b1;
          r.pos = POS_W'(lo);
        end
      end
    end
    r.cnt = (cmp > 63) ? COUNT_W'(63) : COUNT_W'(cmp);
    return r;
  endfunction

  // keys present in the searched range half the time, then near misses, noise and extremes
  function automatic int pick_key(int n);
    int sel, k;
    sel = $urandom_range(99);
    if (n > 0 && sel < 50) k = key_mirror[$urandom_range(n - 1)];
    else if (n > 0 && sel < 65) k = key_mirror[$urandom_range(n - 1)] + ($urandom_range(1) ? 1 : -1);
    else if (sel < 85) k = $urandom;
    else begin
      case ($urandom_range(3))
        0: k = KEY_MIN;
        1: k = KEY_MAX;
        2: k = 0;
        default: k = -1;
      endcase
    end
    return k;
  endfunction

  // value that keeps the table ascending around idx, with a little disorder now and then
  function automatic int sorted_value(int idx);
    longint lo_v, hi_v;
    lo_v = (idx > 0) ? key_mirror[idx - 1] : KEY_MIN;
    hi_v = (idx < TABLE_DEPTH - 1) ? key_mirror[idx + 1] : KEY_MAX;
    if ($urandom_range(99) < 5 || hi_v < lo_v) return $urandom;
    return int'(lo_v + longint'($urandom) % (hi_v - lo_v + 1));
  endfunction

  task automatic add_write(input int idx, input int val);
    stim_row_t row;
    row = '{kind: ROW_ITEM, op: OP_WRITE, idx: INDEX_W'(idx), val: val, key: 0, sel: '0,
            cdata: '0, typed: 1'b0, want: '0};
    dir_rows.push_back(row);
  endtask

  task automatic add_search(input int key);
    stim_row_t row;
    row = '{kind: ROW_ITEM, op: OP_SEARCH, idx: '0, val: 0, key: key, sel: '0,
            cdata: '0, typed: 1'b0, want: '0};
    dir_rows.push_back(row);
  endtask

  task automatic add_check(input int key, input logic f, input int p, input int c);
    stim_row_t row;
    row = '{kind: ROW_ITEM, op: OP_SEARCH, idx: '0, val: 0, key: key, sel: '0,
            cdata: '0, typed: 1'b1, want: '{found: f, pos: POS_W'(p), cnt: COUNT_W'(c)}};
    dir_rows.push_back(row);
  endtask

  task automatic add_cfg(input logic [CFG_INDEX_W-1:0] sel, input int data);
    stim_row_t row;
    row = '{kind: ROW_CFG, op: OP_WRITE, idx: '0, val: 0, key: 0, sel: sel,
            cdata: CFG_DATA_W'(data), typed: 1'b0, want: '0};
    dir_rows.push_back(row);
  endtask

  task automatic push_item(input logic op, input logic [INDEX_W-1:0] idx, input int val,
                           input int key, input bit typed, input search_result_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.opcode      <= op;
    req_ch.write_index <= idx;
    req_ch.write_value <= val;
    req_ch.search_key  <= key;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    // transfer done: update the mirror or queue the expected answer
    if (op == OP_WRITE) key_mirror[idx] = val;
    else pending_results.push_back(typed ? want : predict_search(key));
  endtask

  task automatic settle();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] sel,
                           input logic [CFG_DATA_W-1:0] data);
    settle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= sel;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    if (sel == CFG_SEARCH_MODE) cur_mode = data[0];
    else cur_length = data[LENGTH_W-1:0];
  endtask

  always @(posedge clk) begin
    search_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: found=%0d pos=%0d count=%0d", rsp_ch.found,
                   rsp_ch.match_position, rsp_ch.comparison_count);
      end else begin
        want = pending_results.pop_front();
        if (rsp_ch.found !== want.found || rsp_ch.match_position !== want.pos ||
            rsp_ch.comparison_count !== want.cnt) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected found=%0d pos=%0d count=%0d, %s%0d pos=%0d count=%0d",
                     want.found, want.pos, want.cnt, "got found=", rsp_ch.found,
                     rsp_ch.match_position, rsp_ch.comparison_count);
        end
      end
    end
    rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    int p, i, n, idx;
    logic mode;
    logic [CFG_DATA_W-1:0] len;
    longint acc, stride;
    stim_row_t row;

    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.opcode = OP_WRITE;
    req_ch.write_index = '0;
    req_ch.write_value = '0;
    req_ch.search_key = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_SEARCH_MODE;
    cfg_ch.data = '0;
    cur_mode = MODE_THREE_WAY;
    cur_length = '0;
    send_idle_pct = 19;
    recv_stall_pct = 19;
    foreach (key_mirror[k]) key_mirror[k] = 0;

    // empty table after reset, in both modes
    add_check(5, 1'b0, 0, 0);
    add_check(KEY_MIN, 1'b0, 0, 0);
    add_cfg(CFG_SEARCH_MODE, MODE_LOWER_BOUND);
    add_check(KEY_MAX, 1'b0, 0, 0);
    add_write(0, KEY_MIN);
    add_write(1, -1);
    add_write(2, 0);
    add_write(3, KEY_MAX);
    add_write(TABLE_DEPTH - 1, KEY_MAX);
    // single entry table
    add_cfg(CFG_TABLE_LENGTH, 1);
    add_check(KEY_MIN, 1'b1, 0, 1);
    add_check(7, 1'b0, 0, 1);
    add_cfg(CFG_SEARCH_MODE, MODE_THREE_WAY);
    add_check(KEY_MIN, 1'b1, 0, 1);
    add_check(7, 1'b0, 0, 2);
    add_cfg(CFG_TABLE_LENGTH, 4);
    add_search(KEY_MAX);
    add_search(0);
    add_search(5);
    add_cfg(CFG_SEARCH_MODE, MODE_LOWER_BOUND);
    add_search(-1);
    add_search(KEY_MIN);
    // break the order and search anyway
    add_write(1, KEY_MAX);
    add_search(0);
    add_cfg(CFG_SEARCH_MODE, MODE_THREE_WAY);
    add_search(-1);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[r]) begin
      row = dir_rows[r];
      if (row.kind == ROW_CFG) write_reg(row.sel, row.cdata);
      else if (row.op == OP_WRITE) push_item(OP_WRITE, row.idx, row.val, $urandom, 1'b0, '0);
      else push_item(OP_SEARCH, INDEX_W'($urandom), $urandom, row.key, row.typed, row.want);
    end

    // fill the whole table in ascending order, with runs of equal keys
    send_idle_pct = 0;
    recv_stall_pct = 0;
    settle();
    acc = longint'(KEY_MIN);
    for (i = 0; i < TABLE_DEPTH; i++) begin
      push_item(OP_WRITE, INDEX_W'(i), int'(acc), $urandom, 1'b0, '0);
      if ($urandom_range(3) == 0) stride = longint'($urandom_range(1));
      else stride = longint'($urandom_range(8388608));
      acc += stride;
      if (acc > longint'(KEY_MAX)) acc = longint'(KEY_MAX);
    end

    for (p = 0; p < NUM_PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      mode = ((p / 4 + p) % 2 == 1) ? MODE_LOWER_BOUND : MODE_THREE_WAY;
      case (p)
        0, 1: len = CFG_DATA_W'(TABLE_DEPTH);
        2, 3: len = '1;
        4, 5: len = 1;
        6: len = 2;
        7: len = 3;
        8: len = CFG_DATA_W'(TABLE_DEPTH + 1);
        9: len = 0;
        default: len = (p % 2 == 0) ? CFG_DATA_W'($urandom_range(TABLE_DEPTH, 1))
                                    : CFG_DATA_W'($urandom_range(2047, 1));
      endcase
      write_reg(CFG_SEARCH_MODE, CFG_DATA_W'(mode));
      write_reg(CFG_TABLE_LENGTH, len);
      n = (cur_length > TABLE_DEPTH) ? TABLE_DEPTH : int'(cur_length);
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(99) < 70) begin
          push_item(OP_SEARCH, INDEX_W'($urandom), $urandom, pick_key(n), 1'b0, '0);
        end else begin
          // favor entries inside the searched range
          idx = (n > 0 && $urandom_range(99) < 70) ? $urandom_range(n - 1)
                                                   : $urandom_range(TABLE_DEPTH - 1);
          push_item(OP_WRITE, INDEX_W'(idx), sorted_value(idx), $urandom, 1'b0, '0);
        end
      end
    end

    settle();
    if (errors == 0 && pending_results.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
